// ----- design/utn_pkg.sv -----
// Shared types, constants and helpers for the UTF-8 text token normalizer.
// No dependencies.
package utn_pkg;

    localparam int unsigned MAX_CHAR_BYTES = 7;
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QAW = 2;

    localparam logic [7:0] ASC_SPACE = 8'h20;
    localparam logic [7:0] ASC_APOS = 8'h27;

    // Event from the byte assembler: a complete character or an end of line.
    typedef struct packed {
        logic        eol;
        logic [2:0]  len;
        logic [31:0] v;
    } t_ev;

    // Output bytes caused by one input item, element 0 first.
    typedef struct packed {
        logic [2:0]      cnt;
        logic [5:0][7:0] bytes;
    } t_rec;

    function automatic logic [2:0] lead_length(input logic [7:0] b);
        logic [3:0] n;
        logic ones;
        n = 4'd0;
        ones = 1'b1;
        for (int i = 7; i >= 0; i--) begin
            if (ones && b[i]) begin
                n = n + 4'd1;
            end else begin
                ones = 1'b0;
            end
        end
        if (n < 4'd2) begin
            n = 4'd1;
        end
        if (n > 4'(MAX_CHAR_BYTES)) begin
            n = 4'(MAX_CHAR_BYTES);
        end
        return n[2:0];
    endfunction

endpackage

// ----- design/utn_front.sv -----
// Front: accepts input bytes and assembles UTF-8 characters.
// Uses utn_pkg; emits one registered event per finished character or end of line.
module utn_front import utn_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] in_byte
    input  logic       i_s_tuser,   // [0] action
    output logic       o_ev_valid,
    output t_ev        o_ev,
    input  logic       i_ev_ready
);

    logic [31:0] r_char_bytes, n_char_bytes;
    logic [2:0]  r_char_len, n_char_len;
    logic [2:0]  r_rem, n_rem;
    logic        r_ev_valid;
    t_ev         r_ev, n_ev;
    logic        n_has_ev;
    logic        w_acc, w_take;
    logic [2:0]  w_lead_len;

    assign w_take     = r_ev_valid && i_ev_ready;
    assign o_s_tready = !r_ev_valid || w_take;
    assign w_acc      = i_s_tvalid && o_s_tready;
    assign w_lead_len = lead_length(i_s_tdata);
    assign o_ev_valid = r_ev_valid;
    assign o_ev       = r_ev;

    always_comb begin
        n_char_bytes = r_char_bytes;
        n_char_len   = r_char_len;
        n_rem        = r_rem;
        n_has_ev     = 1'b0;
        n_ev         = r_ev;
        if (i_s_tuser) begin
            n_char_bytes = 32'd0;
            n_char_len   = 3'd0;
            n_rem        = 3'd0;
            n_has_ev     = 1'b1;
            n_ev.eol     = 1'b1;
            n_ev.len     = 3'd0;
            n_ev.v       = 32'd0;
        end else if (r_rem != 3'd0) begin
            n_char_bytes = {r_char_bytes[23:0], i_s_tdata};
            n_rem        = r_rem - 3'd1;
            n_has_ev     = (n_rem == 3'd0);
            n_ev.eol     = 1'b0;
            n_ev.len     = r_char_len;
            n_ev.v       = n_char_bytes;
        end else begin
            n_char_bytes = {24'd0, i_s_tdata};
            n_char_len   = w_lead_len;
            n_rem        = w_lead_len - 3'd1;
            n_has_ev     = (n_rem == 3'd0);
            n_ev.eol     = 1'b0;
            n_ev.len     = w_lead_len;
            n_ev.v       = n_char_bytes;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_char_bytes <= 32'd0;
            r_char_len   <= 3'd0;
            r_rem        <= 3'd0;
            r_ev_valid   <= 1'b0;
        end else if (w_acc) begin
            r_char_bytes <= n_char_bytes;
            r_char_len   <= n_char_len;
            r_rem        <= n_rem;
            r_ev_valid   <= n_has_ev;
        end else if (w_take) begin
            r_ev_valid   <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && n_has_ev) begin
            r_ev <= n_ev;
        end
    end

endmodule

// ----- design/utn_class.sv -----
// Classifier: turns a character or end-of-line event into its output bytes.
// Uses utn_pkg; holds the letter-run flag.
module utn_class import utn_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_ev_valid,
    input  t_ev  i_ev,
    output logic o_ev_ready,
    output logic o_push,
    output t_rec o_rec,
    input  logic i_full
);

    logic            r_run;
    logic [31:0]     w_v;
    logic [2:0]      w_len;
    logic            w_l1a, w_l1b, w_l3a, w_l3b, w_letter;
    logic [7:0]      w_let_b;
    logic            w_apos, w_digit, w_cjk3, w_cjk4;
    logic [4:0][7:0] w_pay;
    logic [2:0]      w_pcnt;
    t_rec            w_rec;
    logic            w_take;

    assign w_v   = i_ev.v;
    assign w_len = i_ev.len;

    assign w_l1a = (w_len == 3'd1) && (w_v >= 32'h41) && (w_v <= 32'h5A);
    assign w_l1b = (w_len == 3'd1) && (w_v >= 32'h61) && (w_v <= 32'h7A);
    assign w_l3a = (w_len == 3'd3) && (w_v >= 32'hEFBCA1) && (w_v <= 32'hEFBCBA);
    assign w_l3b = (w_len == 3'd3) && (w_v >= 32'hEFBD81) && (w_v <= 32'hEFBD9A);
    assign w_letter = w_l1a || w_l1b || w_l3a || w_l3b;

    assign w_apos  = ((w_len == 3'd1) && (w_v == 32'h27)) ||
                     ((w_len == 3'd3) && (w_v == 32'hE28099));
    assign w_digit = (w_len == 3'd1) && (w_v >= 32'h30) && (w_v <= 32'h39);

    assign w_cjk3 = (w_len == 3'd3) && (
        ((w_v >= 32'd14858880) && (w_v <= 32'd14859199)) ||
        ((w_v >= 32'd14913664) && (w_v <= 32'd14988991)) ||
        ((w_v >= 32'd14989440) && (w_v <= 32'd15318975)) ||
        ((w_v >= 32'd15705216) && (w_v <= 32'd15707071)));
    assign w_cjk4 = (w_len == 3'd4) && (
        ((w_v >= 32'd4037050496) && (w_v <= 32'd4037712799)) ||
        ((w_v >= 32'd4037713024) && (w_v <= 32'd4037778623)) ||
        ((w_v >= 32'd4037778816) && (w_v <= 32'd4037779615)) ||
        ((w_v >= 32'd4037779616) && (w_v <= 32'd4037851823)) ||
        ((w_v >= 32'd4037851824) && (w_v <= 32'd4037980079)) ||
        ((w_v >= 32'd4038041728) && (w_v <= 32'd4038043807)));

    always_comb begin
        priority if (w_l3a) begin
            w_let_b = w_v[7:0] - 8'h60;
        end else if (w_l3b) begin
            w_let_b = w_v[7:0] - 8'h40;
        end else begin
            w_let_b = w_v[7:0] & 8'hDF;
        end
    end

    always_comb begin
        w_pay  = '0;
        w_pcnt = 3'd0;
        priority if (w_digit) begin
            w_pay[0] = 8'hEF;
            w_pay[1] = 8'hBC;
            w_pay[2] = w_v[7:0] + 8'h60;
            w_pay[3] = ASC_SPACE;
            w_pcnt   = 3'd4;
        end else if (w_cjk3) begin
            w_pay[0] = w_v[23:16];
            w_pay[1] = w_v[15:8];
            w_pay[2] = w_v[7:0];
            w_pay[3] = ASC_SPACE;
            w_pcnt   = 3'd4;
        end else if (w_cjk4) begin
            w_pay[0] = w_v[31:24];
            w_pay[1] = w_v[23:16];
            w_pay[2] = w_v[15:8];
            w_pay[3] = w_v[7:0];
            w_pay[4] = ASC_SPACE;
            w_pcnt   = 3'd5;
        end else begin
            w_pcnt   = 3'd0;
        end
    end

    always_comb begin
        w_rec = '0;
        priority if (i_ev.eol) begin
            w_rec.bytes[0] = ASC_SPACE;
            w_rec.cnt      = r_run ? 3'd1 : 3'd0;
        end else if (w_letter) begin
            w_rec.bytes[0] = w_let_b;
            w_rec.cnt      = 3'd1;
        end else if (r_run) begin
            w_rec.bytes[0]   = w_apos ? ASC_APOS : ASC_SPACE;
            w_rec.bytes[5:1] = w_pay;
            w_rec.cnt        = w_pcnt + 3'd1;
        end else begin
            w_rec.bytes[4:0] = w_pay;
            w_rec.cnt        = w_pcnt;
        end
    end

    assign w_take     = i_ev_valid && !i_full;
    assign o_ev_ready = !i_full;
    assign o_push     = w_take && (w_rec.cnt != 3'd0);
    assign o_rec      = w_rec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
        end else if (w_take) begin
            r_run <= !i_ev.eol && w_letter;
        end
    end

endmodule

// ----- design/utn_fifo.sv -----
// Short queue of output-byte records between classifier and emitter.
// Uses utn_pkg for the record type and depth.
module utn_fifo import utn_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_rec i_wr_data,
    input  logic i_pop,
    output t_rec o_rd_data,
    output logic o_empty,
    output logic o_full
);

    t_rec           r_mem [QDEPTH];
    logic [QAW-1:0] r_wp, r_rp;
    logic [QAW:0]   r_cnt;
    logic           w_wr, w_rd;

    assign o_empty   = (r_cnt == '0);
    assign o_full    = (r_cnt == (QAW+1)'(QDEPTH));
    assign w_wr      = i_push && !o_full;
    assign w_rd      = i_pop && !o_empty;
    assign o_rd_data = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wp <= r_wp + QAW'(1);
            end
            if (w_rd) begin
                r_rp <= r_rp + QAW'(1);
            end
            if (w_wr && !w_rd) begin
                r_cnt <= r_cnt + (QAW+1)'(1);
            end else if (w_rd && !w_wr) begin
                r_cnt <= r_cnt - (QAW+1)'(1);
            end
        end
    end

endmodule

// ----- design/utn_back.sv -----
// Back end: serializes queued records onto the output stream, one byte per transfer.
// Uses utn_pkg for the record type.
module utn_back import utn_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_rec       i_rec,
    input  logic       i_empty,
    output logic       o_pop,
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] out_byte
    output logic       o_m_tlast
);

    logic            r_busy;
    logic [2:0]      r_cnt;
    logic [5:0][7:0] r_bytes;
    logic            w_fire, w_done;

    assign o_m_tvalid = r_busy;
    assign o_m_tdata  = r_bytes[0];
    assign o_m_tlast  = (r_cnt == 3'd1);
    assign w_fire     = r_busy && i_m_tready;
    assign w_done     = w_fire && (r_cnt == 3'd1);
    assign o_pop      = !i_empty && (!r_busy || w_done);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= 3'd0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_cnt  <= i_rec.cnt;
        end else if (w_done) begin
            r_busy <= 1'b0;
            r_cnt  <= 3'd0;
        end else if (w_fire) begin
            r_cnt  <= r_cnt - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_bytes <= i_rec.bytes;
        end else if (w_fire) begin
            r_bytes <= {8'h00, r_bytes[5:1]};
        end
    end

endmodule

// ----- design/utf8_text_token_normalizer_top.sv -----
// UTF-8 text token normalizer, top level.
// Path: front event register, classifier, queue, then the emitter's byte register.
// Throughput: one input item per cycle while the queue is not full; one output byte per
// cycle from the emitter while the output is ready (queue depth 4).
// Reset: synchronous, active low; clears the character assembler, run flag and queue.
// Uses utn_pkg, utn_front, utn_class, utn_fifo, utn_back.
module utf8_text_token_normalizer_top import utn_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] in_byte
    input  logic       i_s_tuser,   // [0] action
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] out_byte
    output logic       o_m_tlast
);

    logic ev_valid, ev_ready;
    t_ev  ev;
    logic push, pop, empty, full;
    t_rec wr_rec, rd_rec;

    utn_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_ev_valid (ev_valid),
        .o_ev       (ev),
        .i_ev_ready (ev_ready)
    );

    utn_class u_class (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ev_valid (ev_valid),
        .i_ev       (ev),
        .o_ev_ready (ev_ready),
        .o_push     (push),
        .o_rec      (wr_rec),
        .i_full     (full)
    );

    utn_fifo u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_wr_data (wr_rec),
        .i_pop     (pop),
        .o_rd_data (rd_rec),
        .o_empty   (empty),
        .o_full    (full)
    );

    utn_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rec      (rd_rec),
        .i_empty    (empty),
        .o_pop      (pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

endmodule
